// File: rtl/core/fsla_pkg.sv
// Shared types and constants for the fixed-slot free-list allocator.
`timescale 1ns / 1ps
`default_nettype none

package fsla_pkg;

    // Fixed field widths
    localparam int CNT_W   = 11;  // max_entries, allocated_count, slot index quotient
    localparam int ESIZE_W = 13;  // entry_size
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 13;

    // Request codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_SIZE  = 1'b1;

    // Reset values of the registers
    localparam logic [CNT_W-1:0]   MAX_ENTRIES_RST = 11'd1024;
    localparam logic [ESIZE_W-1:0] ENTRY_SIZE_RST  = 13'd16;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_EVAL,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Request from the controller to the divider
    typedef struct packed {
        logic               start;
        logic [ESIZE_W-1:0] divisor;
    } div_req_t;

endpackage

`default_nettype wire

// File: rtl/core/fsla_link_ram.sv
// Link memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fsla_link_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/fsla_div.sv
// Restoring divider producing an 11-bit quotient, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fsla_div
    import fsla_pkg::*;
#(
    parameter int OFFSET_BITS = 22
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire div_req_t               req,
    input  wire logic [OFFSET_BITS-1:0] dividend,
    output logic                        done,
    output logic      [CNT_W-1:0]       quotient
);

    // Caller guarantees dividend < divisor * 2**CNT_W
    localparam int DW_W = OFFSET_BITS + ESIZE_W + CNT_W;
    localparam int SW   = $clog2(CNT_W);

    logic [OFFSET_BITS-1:0] rem_reg, rem_next;
    logic [ESIZE_W-1:0]     dsr_reg, dsr_next;
    logic [CNT_W-1:0]       quot_reg, quot_next;
    logic [SW-1:0]          step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DW_W-1:0]        shifted;
    logic [DW_W-1:0]        rem_ext;

    always_comb
    begin
        shifted   = DW_W'(dsr_reg) << step_reg;
        rem_ext   = DW_W'(rem_reg);
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = dividend;
            dsr_next  = req.divisor;
            quot_next = '0;
            step_next = SW'(CNT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_ext >= shifted)
            begin
                rem_next  = rem_reg - shifted[OFFSET_BITS-1:0];
                quot_next = quot_reg | (CNT_W'(1) << step_reg);
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// File: rtl/core/fsla_ctrl.sv
// Request sequencer: list head, watermark, count, and the result register.
`timescale 1ns / 1ps
`default_nettype none

module fsla_ctrl
    import fsla_pkg::*;
#(
    parameter int SLOT_LIMIT  = 1024,
    parameter int OFFSET_BITS = 22,
    parameter int IDX_W       = 11,
    parameter int AW          = 10
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   operation,
    input  wire logic [OFFSET_BITS-1:0] offset,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [STAT_W-1:0]      status,
    output logic      [OFFSET_BITS-1:0] slot_offset,
    output logic      [CNT_W-1:0]       allocated_count,
    input  wire logic [CNT_W-1:0]       max_entries,
    input  wire logic [ESIZE_W-1:0]     entry_size,
    output logic                        ram_we,
    output logic      [AW-1:0]          ram_waddr,
    output logic      [IDX_W-1:0]       ram_wdata,
    output logic                        ram_re,
    output logic      [AW-1:0]          ram_raddr,
    input  wire logic [IDX_W-1:0]       ram_rdata,
    output div_req_t                    div_req,
    output logic      [OFFSET_BITS-1:0] div_dividend,
    input  wire logic                   div_done,
    input  wire logic [CNT_W-1:0]       div_quot
);

    localparam int MA_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int PW    = MA_W + ESIZE_W;
    localparam int CMP_W = (PW > OFFSET_BITS) ? PW : OFFSET_BITS;

    state_t                 state_reg, state_next;
    logic                   op_reg, op_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic [IDX_W-1:0]       ff_reg, ff_next;
    logic [IDX_W-1:0]       cm_reg, cm_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    status_t                res_stat_reg, res_stat_next;
    logic [OFFSET_BITS-1:0] res_slot_reg, res_slot_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_stat_reg, out_stat_next;
    logic [OFFSET_BITS-1:0] out_slot_reg, out_slot_next;
    logic [CNT_W-1:0]       out_cnt_reg, out_cnt_next;

    logic [CNT_W-1:0]       lim;
    logic [MA_W-1:0]        mul_a;
    logic [CMP_W-1:0]       prod_ext;
    logic [CMP_W-1:0]       off_ext;
    logic [IDX_W-1:0]       cm_inc;
    logic [CNT_W+IDX_W-1:0] quot_ext;
    logic [IDX_W-1:0]       idx;

    always_comb
    begin
        lim      = (32'(max_entries) > SLOT_LIMIT) ? CNT_W'(SLOT_LIMIT) : max_entries;
        mul_a    = (op_reg == OP_FREE) ? MA_W'(lim) : MA_W'(ff_reg);
        prod_ext = CMP_W'(prod_reg);
        off_ext  = CMP_W'(off_reg);
        cm_inc   = (32'(cm_reg) < SLOT_LIMIT) ? cm_reg + 1'b1 : cm_reg;
        quot_ext = {{IDX_W{1'b0}}, div_quot};
        idx      = quot_ext[IDX_W-1:0];

        state_next     = state_reg;
        op_next        = op_reg;
        off_next       = off_reg;
        prod_next      = prod_reg;
        ff_next        = ff_reg;
        cm_next        = cm_reg;
        used_next      = used_reg;
        res_stat_next  = res_stat_reg;
        res_slot_next  = res_slot_reg;
        out_valid_next = out_valid_reg;
        out_stat_next  = out_stat_reg;
        out_slot_next  = out_slot_reg;
        out_cnt_next   = out_cnt_reg;

        in_stall       = (state_reg != ST_IDLE);
        ram_we         = 1'b0;
        ram_waddr      = idx[AW-1:0];
        ram_wdata      = ff_reg;
        ram_re         = 1'b0;
        ram_raddr      = ff_reg[AW-1:0];
        div_req.start   = 1'b0;
        div_req.divisor = entry_size;
        div_dividend    = off_reg;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = operation;
                    off_next   = offset;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                prod_next  = mul_a * entry_size;
                ram_re     = (op_reg == OP_ALLOC);
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                res_slot_next = '0;
                res_stat_next = STAT_DONE;
                state_next    = ST_FINISH;
                if (op_reg == OP_ALLOC)
                begin
                    if (used_reg >= lim)
                    begin
                        res_stat_next = STAT_FULL;
                    end
                    else
                    begin
                        res_slot_next = prod_ext[OFFSET_BITS-1:0];
                        used_next     = used_reg + 1'b1;
                        if (ff_reg == cm_reg)
                        begin
                            cm_next = cm_inc;
                            ff_next = cm_inc;
                        end
                        else
                        begin
                            ff_next = (32'(ff_reg) < SLOT_LIMIT) ? ram_rdata : '0;
                        end
                    end
                end
                else
                begin
                    if ((entry_size == '0) || (off_ext >= prod_ext))
                    begin
                        res_stat_next = STAT_RANGE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    ram_we     = 1'b1;
                    ff_next    = idx;
                    used_next  = (used_reg != '0) ? used_reg - 1'b1 : used_reg;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = res_stat_reg;
                    out_slot_next  = res_slot_reg;
                    out_cnt_next   = used_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ff_reg        <= '0;
            cm_reg        <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ff_reg        <= ff_next;
            cm_reg        <= cm_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        off_reg      <= off_next;
        prod_reg     <= prod_next;
        res_stat_reg <= res_stat_next;
        res_slot_reg <= res_slot_next;
        out_stat_reg <= out_stat_next;
        out_slot_reg <= out_slot_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_stat_reg;
    assign slot_offset     = out_slot_reg;
    assign allocated_count = out_cnt_reg;

endmodule

`default_nettype wire

// File: rtl/core/fixed_slot_free_list_allocator_top.sv
// Top level of the fixed-slot free-list allocator.
`timescale 1ns / 1ps
`default_nettype none

// Slot allocator over one block of max_entries equal slots of entry_size bytes.
// An allocate item (operation 0) returns the byte offset of the head free slot
// and the new allocated count, or status 1 when the block is full. A free item
// (operation 1) checks that offset lies inside the block (status 2 if not),
// turns it into a slot index and pushes that slot on the free list. Freed slots
// are chained through a link memory of SLOT_LIMIT entries; slots above the
// never-used watermark need no link, so there is no clearing pass after reset
// and items are taken from the first cycle. Double frees are not caught.
// Timing: one item is in work at a time. An allocate, and a free that falls
// outside the block, pass the calc, eval and finish states to a valid result;
// an in-range free also waits in the div state for the 11-step restoring
// divider that turns the byte offset into a slot index. The result sits in
// an output register, and a new item is taken in the cycle after it is
// loaded. Write max_entries and entry_size only while the block is idle.

module fixed_slot_free_list_allocator_top
    import fsla_pkg::*;
#(
    parameter int SLOT_LIMIT  = 1024,
    parameter int OFFSET_BITS = 22
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Request channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   operation,
    input  wire logic [OFFSET_BITS-1:0] offset,
    // Result channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [STAT_W-1:0]      status,
    output logic      [OFFSET_BITS-1:0] slot_offset,
    output logic      [CNT_W-1:0]       allocated_count,
    // Register write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Slot indexes run up to SLOT_LIMIT itself (saturated watermark)
    localparam int IDX_W = $clog2(SLOT_LIMIT + 1);
    localparam int AW    = $clog2(SLOT_LIMIT);

    logic [CNT_W-1:0]       max_entries_reg;
    logic [ESIZE_W-1:0]     entry_size_reg;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [IDX_W-1:0]       ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [IDX_W-1:0]       ram_rdata;

    div_req_t               div_req;
    logic [OFFSET_BITS-1:0] div_dividend;
    logic                   div_done;
    logic [CNT_W-1:0]       div_quot;

    // Configuration registers; hold between writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RST;
            entry_size_reg  <= ENTRY_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_ENTRIES:
                begin
                    max_entries_reg <= cfg_data[CNT_W-1:0];
                end
                CFG_ENTRY_SIZE:
                begin
                    entry_size_reg <= cfg_data[ESIZE_W-1:0];
                end
                default:
                begin
                    max_entries_reg <= max_entries_reg;
                end
            endcase
        end
    end

    // Sequencer: reads the link of the head slot on allocate, checks range
    // and starts the divider on free, writes the link back when done
    fsla_ctrl #(
        .SLOT_LIMIT  (SLOT_LIMIT),
        .OFFSET_BITS (OFFSET_BITS),
        .IDX_W       (IDX_W),
        .AW          (AW)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .offset          (offset),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .slot_offset     (slot_offset),
        .allocated_count (allocated_count),
        .max_entries     (max_entries_reg),
        .entry_size      (entry_size_reg),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_re          (ram_re),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .div_req         (div_req),
        .div_dividend    (div_dividend),
        .div_done        (div_done),
        .div_quot        (div_quot)
    );

    // Free-list links, one per slot; contents undefined until written
    fsla_link_ram #(
        .DEPTH (SLOT_LIMIT),
        .AW    (AW),
        .DW    (IDX_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Offset to slot index
    fsla_div #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quot)
    );

endmodule

`default_nettype wire
